// ===== sv/utf8sc_pkg.sv =====
`default_nettype none

package utf8sc_pkg;

  // One input word: the current byte, its lookahead and the page-end flag.
  typedef struct packed {
    logic [7:0] text_byte;
    logic [7:0] next_byte;
    logic       next_valid;
    logic       last_byte;
  } in_word_t;

  // One result word: length of the finished chunk and why it ended.
  typedef struct packed {
    logic [7:0] chunk_bytes;
    logic [2:0] end_reason;
  } out_word_t;

  localparam logic [2:0] REASON_NEWLINE    = 3'd0;
  localparam logic [2:0] REASON_PUNCT      = 3'd1;
  localparam logic [2:0] REASON_LIMIT      = 3'd2;
  localparam logic [2:0] REASON_CUT_SPACE  = 3'd3;
  localparam logic [2:0] REASON_CUT_RUN    = 3'd4;
  localparam logic [2:0] REASON_END_MARK   = 3'd5;
  localparam logic [2:0] REASON_PAGE_END   = 3'd6;

  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_EXCL  = 8'h21;
  localparam logic [7:0] CHAR_QUEST = 8'h3f;
  localparam logic [7:0] CHAR_COMMA = 8'h2c;
  localparam logic [7:0] MARK_FIRST = 8'hff;
  localparam logic [7:0] MARK_SECOND = 8'hfe;

  localparam logic [3:0] LEAD3_HIGH = 4'he;
  localparam logic [2:0] LEAD2_HIGH = 3'b110;

  localparam logic [5:0] MAX_CHARS_RESET = 6'd50;

endpackage

`default_nettype wire

// ===== sv/utf8_sentence_chunker.sv =====
// Channel   Direction  Handshake           Payload
// in_       input      in_valid/in_stall   in_data   (in_word_t)
// out_      output     out_valid/out_stall out_data  (out_word_t)
// cfg_      input      cfg_wr_en           cfg_wr_data (max_chars)
//
// One word is taken per cycle while in_stall is low; its chunk state update and any result are
// computed in the same cycle and the result lands in the output register.
// The result appears on out_ in the cycle after its word is accepted.
// in_stall is high only while the output register is full and stalled.
// Synchronous active-low reset clears the chunk state, empties the output
// register and sets max_chars to 50.
`default_nettype none

module utf8_sentence_chunker
  import utf8sc_pkg::*;
#(
  parameter int LEN_BITS = 8
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_data,
  input  wire logic      cfg_wr_en,
  input  wire logic [5:0] cfg_wr_data
);

  typedef struct packed {
    logic [LEN_BITS-1:0] chunk_len;
    logic [5:0]          char_count;
    logic [5:0]          ascii_run;
    logic [LEN_BITS-1:0] run_start;
    logic [LEN_BITS-1:0] last_space_pos;
    logic                space_seen;
    logic [1:0]          cont_left;
    logic                end_after_next;
  } chunk_state_t;

  chunk_state_t        st_r, st_nxt;
  logic [5:0]          max_chars_r;
  logic                out_valid_r;
  out_word_t           out_data_r;

  logic                fire_in;
  logic                emit;
  logic [LEN_BITS-1:0] res_len;
  logic [2:0]          res_reason;

  logic [7:0]          b, nb;
  logic                nv, lastb;
  logic                is_nl, is_mark, is_lead3, is_lead2, is_space, is_punct, nb_space;
  logic [LEN_BITS-1:0] len_inc;
  logic [5:0]          cc_inc, run_inc;
  logic [LEN_BITS-1:0] rs_cur, lsp_cur, keep_sp, sppos;
  logic                ss_cur, sp_ok, rs_sp;

  assign b     = in_data.text_byte;
  assign nb    = in_data.next_byte;
  assign nv    = in_data.next_valid;
  assign lastb = in_data.last_byte;

  assign in_stall = out_valid_r && out_stall;
  assign fire_in  = in_valid && !in_stall;

  assign is_nl    = (b == CHAR_LF) || (b == CHAR_CR);
  assign is_mark  = (b == MARK_FIRST) && nv && (nb == MARK_SECOND);
  assign is_lead3 = (b[7:4] == LEAD3_HIGH);
  assign is_lead2 = (b[7:5] == LEAD2_HIGH);
  assign is_space = (b == CHAR_SPACE) || (b == CHAR_TAB);
  assign is_punct = (b == CHAR_EXCL) || (b == CHAR_QUEST) || (b == CHAR_COMMA);
  assign nb_space = nv && ((nb == CHAR_SPACE) || (nb == CHAR_TAB));

  assign len_inc = st_r.chunk_len + LEN_BITS'(1);
  assign cc_inc  = st_r.char_count + 6'd1;
  assign run_inc = st_r.ascii_run + 6'd1;

  // Position bookkeeping as it stands after this byte is placed.
  assign rs_cur  = (st_r.ascii_run == 6'd0) ? st_r.chunk_len : st_r.run_start;
  assign lsp_cur = is_space ? st_r.chunk_len : st_r.last_space_pos;
  assign ss_cur  = is_space || st_r.space_seen;

  assign keep_sp = len_inc - lsp_cur;
  assign sp_ok   = ss_cur && (lsp_cur < len_inc) &&
                   (keep_sp < {{(LEN_BITS-6){1'b0}}, max_chars_r});
  assign rs_sp   = ss_cur && (lsp_cur >= rs_cur);
  assign sppos   = rs_sp ? (lsp_cur - rs_cur) : '0;

  always_comb begin
    st_nxt     = st_r;
    emit       = 1'b0;
    res_len    = '0;
    res_reason = REASON_NEWLINE;

    if (st_r.end_after_next) begin
      // Second byte of a newline pair closes the chunk whatever it holds.
      emit    = 1'b1;
      res_len = len_inc;
      st_nxt  = '0;
    end else if (st_r.cont_left != 2'd0) begin
      st_nxt.chunk_len = len_inc;
      st_nxt.cont_left = st_r.cont_left - 2'd1;
      if (st_r.cont_left == 2'd1 && st_r.char_count >= max_chars_r) begin
        emit       = 1'b1;
        res_len    = len_inc;
        res_reason = REASON_LIMIT;
        st_nxt     = '0;
      end
    end else if (is_nl) begin
      if (nv && nb == CHAR_LF && !lastb) begin
        st_nxt.chunk_len      = len_inc;
        st_nxt.end_after_next = 1'b1;
      end else begin
        emit    = 1'b1;
        res_len = len_inc;
        st_nxt  = '0;
      end
    end else if (is_mark) begin
      emit       = 1'b1;
      res_len    = st_r.chunk_len;
      res_reason = REASON_END_MARK;
      st_nxt     = '0;
    end else if (is_lead3 || is_lead2) begin
      st_nxt.char_count = cc_inc;
      st_nxt.chunk_len  = len_inc;
      st_nxt.ascii_run  = 6'd0;
      st_nxt.cont_left  = is_lead3 ? 2'd2 : 2'd1;
    end else begin
      st_nxt.run_start      = rs_cur;
      st_nxt.chunk_len      = len_inc;
      st_nxt.last_space_pos = lsp_cur;
      st_nxt.space_seen     = ss_cur;
      if (is_punct) begin
        emit       = 1'b1;
        res_len    = len_inc;
        res_reason = REASON_PUNCT;
        st_nxt     = '0;
      end else begin
        st_nxt.ascii_run  = run_inc;
        st_nxt.char_count = cc_inc;
        if (cc_inc >= max_chars_r) begin
          emit = 1'b1;
          if (run_inc >= max_chars_r) begin
            if (max_chars_r != 6'd0 && nb_space) begin
              // The space is the next byte, so nothing needs to be cut.
              res_len    = len_inc;
              res_reason = REASON_CUT_SPACE;
              st_nxt     = '0;
            end else if (sp_ok) begin
              res_len           = lsp_cur;
              res_reason        = REASON_CUT_SPACE;
              st_nxt            = '0;
              st_nxt.chunk_len  = keep_sp;
              st_nxt.char_count = keep_sp[5:0];
              st_nxt.ascii_run  = keep_sp[5:0];
              st_nxt.space_seen = 1'b1;
            end else begin
              res_len    = len_inc;
              res_reason = REASON_LIMIT;
              st_nxt     = '0;
            end
          end else begin
            // The short ASCII run moves whole into the next chunk.
            res_len               = rs_cur;
            res_reason            = REASON_CUT_RUN;
            st_nxt                = '0;
            st_nxt.chunk_len      = {{(LEN_BITS-6){1'b0}}, run_inc};
            st_nxt.char_count     = run_inc;
            st_nxt.ascii_run      = run_inc;
            st_nxt.space_seen     = rs_sp;
            st_nxt.last_space_pos = sppos;
          end
        end
      end
    end

    if (lastb) begin
      if (!emit && st_nxt.chunk_len != '0) begin
        emit       = 1'b1;
        res_len    = st_nxt.chunk_len;
        res_reason = REASON_PAGE_END;
      end
      st_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      max_chars_r <= MAX_CHARS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_chars_r <= cfg_wr_data;
      end
      if (fire_in) begin
        st_r <= st_nxt;
      end
      if (fire_in && emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire_in && emit) begin
      out_data_r.chunk_bytes <= res_len[7:0];
      out_data_r.end_reason  <= res_reason;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== sv/utf8sc_checker.sv =====
`default_nettype none

module utf8sc_checker
  import utf8sc_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire out_word_t  out_data
);

  // The output register is empty right after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word present after reset");

  // Input back-pressure comes only from a full, stalled output register.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a held result");

  // Newline, punctuation and page-end chunks always hold at least one byte.
  a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.end_reason == REASON_NEWLINE ||
                  out_data.end_reason == REASON_PUNCT ||
                  out_data.end_reason == REASON_PAGE_END)
      |-> (out_data.chunk_bytes != 8'd0))
    else $error("empty chunk with a reason that needs content");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result word changed while stalled");

endmodule

bind utf8_sentence_chunker utf8sc_checker u_utf8sc_checker (.*);

`default_nettype wire
